[rtl/r2fft_pkg.sv]
// ----------------------------------------------------------------------------
// r2fft_pkg: shared constants and helpers of the radix-2 FFT unit
// Holds the sizes of the frame store, the twiddle table and the arithmetic
// helpers that the FFT unit uses.
// ----------------------------------------------------------------------------
package r2fft_pkg;

   localparam int MAX_POINTS   = 2048;
   localparam int MAX_LOG2     = 11;
   localparam int MIN_LOG2     = 3;
   localparam int ADDR_W       = 11;
   localparam int CNT_W        = 12;
   localparam int LOG_W        = 4;
   localparam int TWIDDLE_BITS = 16;
   localparam int TW_FRAC      = TWIDDLE_BITS - 1;
   localparam int QUARTER      = MAX_POINTS / 4;
   localparam int TW_IDX_W     = 10;
   localparam int WORD_W       = 28;
   localparam int DIFF_W       = WORD_W + 1;
   localparam int COEF_W       = TWIDDLE_BITS + 1;
   localparam int PROD_W       = DIFF_W + COEF_W;
   localparam int ACC_W        = PROD_W + 1;
   localparam int SAMPLE_W     = 16;
   localparam int CSR_W        = 4;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // Request actions.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Register indexes.
   localparam logic CSR_INVERSE = 1'b0;
   localparam logic CSR_POINTS  = 1'b1;

   typedef logic [TWIDDLE_BITS-1:0] sin_table_type [0:QUARTER];

   // Q2.30 Taylor series of sin(x), evaluated at elaboration only.
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      return 64'(sum);
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type t;
      logic [63:0]   x;
      logic [63:0]   r;
      for (int j = 0; j <= QUARTER; j++) begin
         x = (64'd2 * PI_Q30 * 64'(j)) / MAX_POINTS;
         r = (sin_q30(x) + (64'd1 << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);
         if (r > 64'((1 << TW_FRAC) - 1)) r = 64'((1 << TW_FRAC) - 1);
         t[j] = TWIDDLE_BITS'(r);
      end
      return t;
   endfunction

   localparam sin_table_type SIN_TABLE = build_sin_table();

   // Clamp a wide value to the signed 28-bit word range.
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-WORD_W:0] top;
      top = v[ACC_W-1:WORD_W-1];
      if ((&top) || (~|top)) return v[WORD_W-1:0];
      else if (v[ACC_W-1]) return {1'b1, {(WORD_W-1){1'b0}}};
      else return {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

endpackage

[rtl/r2fft_ram.sv]
// ----------------------------------------------------------------------------
// r2fft_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module r2fft_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

[rtl/radix2_fft_inverse_capable_unit.sv]
// ----------------------------------------------------------------------------
// radix2_fft_inverse_capable_unit: in-place radix-2 DIF FFT
// Frame store, one shared butterfly multiplier and the sequencer around it.
// ----------------------------------------------------------------------------
// Samples are loaded one per transfer with action 0; the transfer that fills
// the frame of N = 2^points_log2 points starts the transform, during which
// req_ready stays low. Each butterfly reads its two points, forms their sum
// and difference, takes four products through the single multiplier and
// writes through the single write port of the frame store; a bit-reversal
// pass follows that also applies the 1/N scaling in inverse mode. A load
// writes its sample into the frame store, a read of a finished bin goes
// through the registered read port of the frame store, and a read before
// the transform is done answers with zeros.
module radix2_fft_inverse_capable_unit
   import r2fft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic signed [SAMPLE_W-1:0] req_sample_real,
   input  logic signed [SAMPLE_W-1:0] req_sample_imag,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_bin_real,
   output logic signed [WORD_W-1:0]   rsp_bin_imag,
   output logic                       rsp_bin_valid,
   output logic                       rsp_bin_last,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_BF_RD = 4'd2;
   localparam logic [3:0] ST_BF_OP = 4'd3;
   localparam logic [3:0] ST_BF_M0 = 4'd4;
   localparam logic [3:0] ST_BF_M1 = 4'd5;
   localparam logic [3:0] ST_BF_M2 = 4'd6;
   localparam logic [3:0] ST_BF_M3 = 4'd7;
   localparam logic [3:0] ST_BF_WR = 4'd8;
   localparam logic [3:0] ST_SW_RD = 4'd9;
   localparam logic [3:0] ST_SW_DT = 4'd10;
   localparam logic [3:0] ST_SW_W0 = 4'd11;
   localparam logic [3:0] ST_SW_W1 = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        load_count_ff, load_count_in;
   logic [CNT_W-1:0]        read_count_ff, read_count_in;
   logic                    done_ff, done_in;
   logic                    inverse_ff;
   logic [LOG_W-1:0]        points_ff;
   logic [LOG_W-1:0]        xf_m_ff, xf_m_in;
   logic                    xf_inv_ff, xf_inv_in;
   logic [LOG_W-1:0]        h_ff, h_in;
   logic [ADDR_W-1:0]       j_ff, j_in;
   logic                    last_ff, last_in;

   logic signed [WORD_W-1:0] sum_r_ff, sum_r_in, sum_i_ff, sum_i_in;
   logic signed [DIFF_W-1:0] dr_ff, dr_in, di_ff, di_in;
   logic signed [COEF_W-1:0] c_ff, c_in, s_ff, s_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [WORD_W-1:0] res_r_ff, res_r_in;
   logic signed [WORD_W-1:0] xk_r_ff, xk_r_in, xk_i_ff, xk_i_in;
   logic signed [WORD_W-1:0] xr_r_ff, xr_r_in, xr_i_ff, xr_i_in;
   logic [TWIDDLE_BITS-1:0]  sin_rom_ff, cos_rom_ff;
   logic                     cneg_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] bin_real_ff, bin_real_in, bin_imag_ff, bin_imag_in;
   logic                     bin_valid_ff, bin_valid_in, bin_last_ff, bin_last_in;

   // Frame store ports.
   logic                     we;
   logic [ADDR_W-1:0]        wa, ra, rb;
   logic [WORD_W-1:0]        wd_r, wd_i;
   logic [WORD_W-1:0]        ra_r, ra_i, rb_r, rb_i;

   logic                     req_fire;
   logic [LOG_W-1:0]         eff_m;
   logic [CNT_W-1:0]         n_cur;
   logic [ADDR_W-1:0]        p_mask, bf_k, bf_kb, half_last, n_xf_last, sw_r, rev_full;
   logic [TW_IDX_W-1:0]      tw_e, tw_sin_idx, tw_cos_idx;
   logic                     tw_cneg;
   logic signed [DIFF_W-1:0] mul_a;
   logic signed [COEF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;

   // Round half up and saturate a product sum back to a word.
   function automatic logic signed [WORD_W-1:0] round_prod(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = (v + (ACC_W'(1) <<< (TW_FRAC - 1))) >>> TW_FRAC;
      return sat_word(t);
   endfunction

   // Inverse-mode division by N with rounding half up.
   function automatic logic signed [WORD_W-1:0] scale_word(input logic signed [WORD_W-1:0] v,
                                                          input logic inv,
                                                          input logic [LOG_W-1:0] m);
      logic signed [DIFF_W-1:0] t;
      t = (signed'({v[WORD_W-1], v}) + (DIFF_W'(1) << (m - LOG_W'(1)))) >>> m;
      if (inv) return t[WORD_W-1:0];
      else return v;
   endfunction

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (points_ff < LOG_W'(MIN_LOG2)) eff_m = LOG_W'(MIN_LOG2);
      else if (points_ff > LOG_W'(MAX_LOG2)) eff_m = LOG_W'(MAX_LOG2);
      else eff_m = points_ff;
   end
   assign n_cur = CNT_W'(1) << eff_m;

   // Butterfly addressing: insert a zero at bit h of the butterfly count.
   assign p_mask    = (ADDR_W'(1) << h_ff) - ADDR_W'(1);
   assign bf_k      = ((j_ff & ~p_mask) << 1) | (j_ff & p_mask);
   assign bf_kb     = bf_k | (ADDR_W'(1) << h_ff);
   assign half_last = (ADDR_W'(1) << (xf_m_ff - LOG_W'(1))) - ADDR_W'(1);
   assign n_xf_last = (ADDR_W'(1) << xf_m_ff) - ADDR_W'(1);
   assign tw_e      = TW_IDX_W'((bf_k & p_mask) << (LOG_W'(MAX_LOG2 - 1) - h_ff));

   always_comb begin
      for (int i = 0; i < ADDR_W; i++) rev_full[i] = j_ff[ADDR_W-1-i];
   end
   assign sw_r = rev_full >> (LOG_W'(MAX_LOG2) - xf_m_ff);

   // Cosine and the second half-period come from the quarter-wave sine table.
   always_comb begin
      if (tw_e <= TW_IDX_W'(QUARTER)) begin
         tw_sin_idx = tw_e;
         tw_cos_idx = TW_IDX_W'(QUARTER) - tw_e;
         tw_cneg    = 1'b0;
      end else begin
         tw_sin_idx = TW_IDX_W'(2 * QUARTER) - tw_e;
         tw_cos_idx = tw_e - TW_IDX_W'(QUARTER);
         tw_cneg    = 1'b1;
      end
   end

   // The one shared multiplier.
   always_comb begin
      case (state_ff)
         ST_BF_M0: begin mul_a = dr_ff; mul_b = c_ff; end
         ST_BF_M1: begin mul_a = di_ff; mul_b = s_ff; end
         ST_BF_M2: begin mul_a = di_ff; mul_b = c_ff; end
         default:  begin mul_a = dr_ff; mul_b = s_ff; end
      endcase
   end
   assign prod = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      read_count_in = read_count_ff;
      done_in       = done_ff;
      xf_m_in       = xf_m_ff;
      xf_inv_in     = xf_inv_ff;
      h_in          = h_ff;
      j_in          = j_ff;
      last_in       = last_ff;
      sum_r_in      = sum_r_ff;
      sum_i_in      = sum_i_ff;
      dr_in         = dr_ff;
      di_in         = di_ff;
      c_in          = c_ff;
      s_in          = s_ff;
      acc_in        = acc_ff;
      res_r_in      = res_r_ff;
      xk_r_in       = xk_r_ff;
      xk_i_in       = xk_i_ff;
      xr_r_in       = xr_r_ff;
      xr_i_in       = xr_i_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      bin_real_in   = bin_real_ff;
      bin_imag_in   = bin_imag_ff;
      bin_valid_in  = bin_valid_ff;
      bin_last_in   = bin_last_ff;
      we            = 1'b0;
      wa            = bf_k;
      wd_r          = '0;
      wd_i          = '0;
      ra            = bf_k;
      rb            = bf_kb;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_LOAD) begin
                  we            = 1'b1;
                  wa            = load_count_ff[ADDR_W-1:0];
                  wd_r          = WORD_W'(req_sample_real);
                  wd_i          = WORD_W'(req_sample_imag);
                  done_in       = 1'b0;
                  read_count_in = '0;
                  if (load_count_ff + CNT_W'(1) >= n_cur) begin
                     load_count_in = '0;
                     xf_m_in       = eff_m;
                     xf_inv_in     = inverse_ff;
                     h_in          = eff_m - LOG_W'(1);
                     j_in          = '0;
                     state_in      = ST_BF_RD;
                  end else begin
                     load_count_in = load_count_ff + CNT_W'(1);
                  end
               end else if (done_ff) begin
                  ra      = read_count_ff[ADDR_W-1:0];
                  last_in = (read_count_ff + CNT_W'(1)) >= n_cur;
                  if ((read_count_ff + CNT_W'(1)) >= n_cur) begin
                     done_in       = 1'b0;
                     read_count_in = '0;
                  end else begin
                     read_count_in = read_count_ff + CNT_W'(1);
                  end
                  state_in = ST_READ;
               end else begin
                  // A read before the transform is done answers with zeros.
                  rsp_valid_in = 1'b1;
                  bin_real_in  = '0;
                  bin_imag_in  = '0;
                  bin_valid_in = 1'b0;
                  bin_last_in  = 1'b0;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            bin_real_in  = ra_r;
            bin_imag_in  = ra_i;
            bin_valid_in = 1'b1;
            bin_last_in  = last_ff;
            state_in     = ST_IDLE;
         end
         ST_BF_RD: begin
            state_in = ST_BF_OP;
         end
         ST_BF_OP: begin
            sum_r_in = sat_word(ACC_W'(signed'(ra_r)) + ACC_W'(signed'(rb_r)));
            sum_i_in = sat_word(ACC_W'(signed'(ra_i)) + ACC_W'(signed'(rb_i)));
            dr_in    = DIFF_W'(signed'(ra_r)) - DIFF_W'(signed'(rb_r));
            di_in    = DIFF_W'(signed'(ra_i)) - DIFF_W'(signed'(rb_i));
            c_in     = cneg_ff ? -signed'(COEF_W'(cos_rom_ff)) : signed'(COEF_W'(cos_rom_ff));
            s_in     = xf_inv_ff ? -signed'(COEF_W'(sin_rom_ff)) : signed'(COEF_W'(sin_rom_ff));
            state_in = ST_BF_M0;
         end
         ST_BF_M0: begin
            we       = 1'b1;
            wa       = bf_k;
            wd_r     = sum_r_ff;
            wd_i     = sum_i_ff;
            acc_in   = ACC_W'(prod);
            state_in = ST_BF_M1;
         end
         ST_BF_M1: begin
            acc_in   = acc_ff - ACC_W'(prod);
            state_in = ST_BF_M2;
         end
         ST_BF_M2: begin
            res_r_in = round_prod(acc_ff);
            acc_in   = ACC_W'(prod);
            state_in = ST_BF_M3;
         end
         ST_BF_M3: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_BF_WR;
         end
         ST_BF_WR: begin
            we   = 1'b1;
            wa   = bf_kb;
            wd_r = res_r_ff;
            wd_i = round_prod(acc_ff);
            if (j_ff == half_last) begin
               j_in = '0;
               if (h_ff == '0) state_in = ST_SW_RD;
               else begin
                  h_in     = h_ff - LOG_W'(1);
                  state_in = ST_BF_RD;
               end
            end else begin
               j_in     = j_ff + ADDR_W'(1);
               state_in = ST_BF_RD;
            end
         end
         ST_SW_RD: begin
            ra       = j_ff;
            rb       = sw_r;
            state_in = ST_SW_DT;
         end
         ST_SW_DT: begin
            xk_r_in = scale_word(ra_r, xf_inv_ff, xf_m_ff);
            xk_i_in = scale_word(ra_i, xf_inv_ff, xf_m_ff);
            xr_r_in = scale_word(rb_r, xf_inv_ff, xf_m_ff);
            xr_i_in = scale_word(rb_i, xf_inv_ff, xf_m_ff);
            if (j_ff < sw_r) state_in = ST_SW_W0;
            else if (j_ff == sw_r) state_in = ST_SW_W1;
            else if (j_ff == n_xf_last) begin
               j_in     = '0;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               j_in     = j_ff + ADDR_W'(1);
               state_in = ST_SW_RD;
            end
         end
         ST_SW_W0: begin
            we       = 1'b1;
            wa       = j_ff;
            wd_r     = xr_r_ff;
            wd_i     = xr_i_ff;
            state_in = ST_SW_W1;
         end
         ST_SW_W1: begin
            we   = 1'b1;
            wa   = sw_r;
            wd_r = xk_r_ff;
            wd_i = xk_i_ff;
            if (j_ff == n_xf_last) begin
               j_in     = '0;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               j_in     = j_ff + ADDR_W'(1);
               state_in = ST_SW_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         read_count_ff <= '0;
         done_ff       <= 1'b0;
         inverse_ff    <= 1'b0;
         points_ff     <= LOG_W'(MAX_LOG2);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         read_count_ff <= read_count_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INVERSE: inverse_ff <= csr_wdata[0];
               CSR_POINTS:  points_ff  <= csr_wdata;
               default:     inverse_ff <= inverse_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      xf_m_ff     <= xf_m_in;
      xf_inv_ff   <= xf_inv_in;
      h_ff        <= h_in;
      j_ff        <= j_in;
      last_ff     <= last_in;
      sum_r_ff    <= sum_r_in;
      sum_i_ff    <= sum_i_in;
      dr_ff       <= dr_in;
      di_ff       <= di_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      acc_ff      <= acc_in;
      res_r_ff    <= res_r_in;
      xk_r_ff     <= xk_r_in;
      xk_i_ff     <= xk_i_in;
      xr_r_ff     <= xr_r_in;
      xr_i_ff     <= xr_i_in;
      sin_rom_ff  <= SIN_TABLE[tw_sin_idx];
      cos_rom_ff  <= SIN_TABLE[tw_cos_idx];
      cneg_ff     <= tw_cneg;
      bin_real_ff <= bin_real_in;
      bin_imag_ff <= bin_imag_in;
      bin_valid_ff <= bin_valid_in;
      bin_last_ff <= bin_last_in;
   end

   r2fft_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram_real (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (wa),
      .wr_data   (wd_r),
      .rd_addr_a (ra),
      .rd_data_a (ra_r),
      .rd_addr_b (rb),
      .rd_data_b (rb_r)
   );

   r2fft_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram_imag (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (wa),
      .wr_data   (wd_i),
      .rd_addr_a (ra),
      .rd_data_a (ra_i),
      .rd_addr_b (rb),
      .rd_data_b (rb_i)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_real  = bin_real_ff;
   assign rsp_bin_imag  = bin_imag_ff;
   assign rsp_bin_valid = bin_valid_ff;
   assign rsp_bin_last  = bin_last_ff;

   // A finished frame always restarts loading from the first sample.
   a_done_load_zero: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> load_count_ff == '0)
      else $error("transform done with a partial frame loaded");

   // The transform runs only with the done flag cleared.
   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_READ) |-> !done_ff)
      else $error("done flag set while the transform runs");

   // Only a load transfer writes the frame store while idle.
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (we && state_ff == ST_IDLE) |-> (req_fire && req_action == ACT_LOAD))
      else $error("frame store written without a load transfer");

   // A last bin is always a delivered bin.
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && bin_last_ff) |-> bin_valid_ff)
      else $error("last flag on an invalid bin");

endmodule
